// ----- hdl/led_error_code_blinker_core_assert.svh -----
// Assertion macros shared by the blinker RTL
`ifndef LED_ERROR_CODE_BLINKER_CORE_ASSERT_SVH
`define LED_ERROR_CODE_BLINKER_CORE_ASSERT_SVH

// Checked only out of reset
`define LEDB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// Checked at every edge, reset included
`define LEDB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
  else $error(msg);

`endif

// ----- hdl/ledb_pkg.sv -----
// Shared types, constants and digit arithmetic for the LED error code blinker
`default_nettype none

package ledb_pkg;

  localparam int QueueDepthDef   = 10;
  localparam int TickPrescaleDef = 10;

  localparam int TimeW    = 8;
  localparam int CodeW    = 8;
  localparam int KindW    = 2;
  localparam int QueuedW  = 4;
  localparam int CfgIdxW  = 3;
  localparam int WeightW  = 7;
  localparam int DigitW   = 4;

  localparam logic [TimeW-1:0] HdrOnRst    = 8'd200;
  localparam logic [TimeW-1:0] HdrOffRst   = 8'd150;
  localparam logic [TimeW-1:0] FlashOnRst  = 8'd48;
  localparam logic [TimeW-1:0] FlashOffRst = 8'd24;
  localparam logic [TimeW-1:0] DigitGapRst = 8'd150;
  localparam logic [TimeW-1:0] TailRst     = 8'd200;
  localparam logic [TimeW-1:0] BlipOnRst   = 8'd2;
  localparam logic [TimeW-1:0] ValueGapRst = 8'd200;

  typedef enum logic [KindW-1:0] {
    KindTick  = 2'd0,
    KindPush  = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHdrOn    = 3'd0,
    CfgHdrOff   = 3'd1,
    CfgFlashOn  = 3'd2,
    CfgFlashOff = 3'd3,
    CfgDigitGap = 3'd4,
    CfgTail     = 3'd5,
    CfgBlipOn   = 3'd6,
    CfgValueGap = 3'd7
  } cfg_reg_e;

  typedef enum logic [5:0] {
    PhWait   = 6'b000001,
    PhHeader = 6'b000010,
    PhDigit  = 6'b000100,
    PhUnitOn = 6'b001000,
    PhBlip   = 6'b010000,
    PhBlipOn = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [TimeW-1:0] hdr_on;
    logic [TimeW-1:0] hdr_off;
    logic [TimeW-1:0] flash_on;
    logic [TimeW-1:0] flash_off;
    logic [TimeW-1:0] digit_gap;
    logic [TimeW-1:0] tail;
    logic [TimeW-1:0] blip_on;
    logic [TimeW-1:0] value_gap;
  } times_t;

  // Queue side view handed to the sequencer for one transaction
  typedef struct packed {
    logic             base_tick;
    logic             clear;
    logic             ready;
    logic             code_avail;
    logic [CodeW-1:0] head_code;
  } seq_in_t;

  // Sequencer requests back to the queue
  typedef struct packed {
    logic start;
    logic load;
  } seq_req_t;

  typedef struct packed {
    logic [CodeW-1:0]   rem;
    logic [WeightW-1:0] weight;
    logic [DigitW-1:0]  units;
  } digits_t;

  // Exact v / 10 for any 8-bit v
  function automatic logic [7:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * 16'd205;
    return 8'(p >> 11);
  endfunction

  // Leading digit of a code, skipping leading zeros
  function automatic digits_t split_code(input logic [CodeW-1:0] v);
    digits_t    r;
    logic [7:0] q;
    q = div10(v);
    priority if (v >= 8'd200) begin
      r.units  = 4'd2;
      r.rem    = v - 8'd200;
      r.weight = 7'd100;
    end else if (v >= 8'd100) begin
      r.units  = 4'd1;
      r.rem    = v - 8'd100;
      r.weight = 7'd100;
    end else if (q != 8'd0) begin
      r.units  = q[DigitW-1:0];
      r.rem    = v - 8'(q * 8'd10);
      r.weight = 7'd10;
    end else if (v != 8'd0) begin
      r.units  = v[DigitW-1:0];
      r.rem    = 8'd0;
      r.weight = 7'd1;
    end else begin
      r.units  = 4'd0;
      r.rem    = 8'd0;
      r.weight = 7'd0;
    end
    return r;
  endfunction

  // Step down one decimal place
  function automatic digits_t next_digit(input logic [CodeW-1:0] rem,
                                         input logic [WeightW-1:0] weight);
    digits_t            r;
    logic [WeightW-1:0] w;
    logic [7:0]         q;
    w = 7'(div10({1'b0, weight}));
    q = div10(rem);
    r.weight = w;
    priority if (w == 7'd10) begin
      r.units = q[DigitW-1:0];
      r.rem   = rem - 8'(q * 8'd10);
    end else if (w == 7'd1) begin
      r.units = rem[DigitW-1:0];
      r.rem   = 8'd0;
    end else begin
      r.units = 4'd0;
      r.rem   = rem;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ledb_ram.sv -----
// Generic single write port RAM with registered read
`default_nettype none

module ledb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 10,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AddrW-1:0]  wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic [AddrW-1:0]  rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- hdl/ledb_seq.sv -----
// Blink sequencer: prescaler, duration timer, phase and digit state
`default_nettype none

module ledb_seq
  import ledb_pkg::*;
#(
  parameter int TICK_PRESCALE = TickPrescaleDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire times_t   times_i,
  input  wire logic     fire_i,
  input  wire seq_in_t  seq_i,
  output seq_req_t      req_o,
  output logic          led_d_o
);

  localparam int PsW = $clog2(TICK_PRESCALE + 1);

  phase_e             phase_q, phase_d;
  logic [TimeW-1:0]   timer_q, timer_d;
  logic [CodeW-1:0]   rem_q, rem_d;
  logic [WeightW-1:0] weight_q, weight_d;
  logic [DigitW-1:0]  units_q, units_d;
  logic [PsW-1:0]     ps_q, ps_d;
  logic               led_q, led_d;

  digits_t loaded;
  digits_t stepped;

  assign loaded  = split_code(seq_i.head_code);
  assign stepped = next_digit(rem_q, weight_q);

  always_comb begin
    phase_d  = phase_q;
    timer_d  = timer_q;
    rem_d    = rem_q;
    weight_d = weight_q;
    units_d  = units_q;
    ps_d     = ps_q;
    led_d    = led_q;
    req_o    = '0;

    if (fire_i && seq_i.clear) begin
      led_d   = 1'b0;
      phase_d = PhWait;
    end else if (fire_i && seq_i.base_tick) begin
      if (ps_q > PsW'(1)) begin
        ps_d = ps_q - PsW'(1);
      end else begin
        ps_d = PsW'(TICK_PRESCALE);
        if (timer_q > 8'd1) begin
          timer_d = timer_q - 8'd1;
        end else begin
          unique case (phase_q)
            PhWait: begin
              if (seq_i.ready) begin
                req_o.start = 1'b1;
                led_d       = 1'b1;
                timer_d     = times_i.hdr_on;
                phase_d     = PhHeader;
              end
            end
            PhHeader: begin
              led_d   = 1'b0;
              timer_d = times_i.hdr_off;
              phase_d = PhDigit;
              if (seq_i.code_avail) begin
                req_o.load = 1'b1;
                rem_d      = loaded.rem;
                weight_d   = loaded.weight;
                units_d    = loaded.units;
              end
            end
            PhDigit: begin
              if (units_q != 4'd0) begin
                led_d   = 1'b1;
                timer_d = times_i.flash_on;
                phase_d = PhUnitOn;
              end else if (rem_q != 8'd0) begin
                rem_d    = stepped.rem;
                weight_d = stepped.weight;
                units_d  = stepped.units;
                timer_d  = times_i.digit_gap;
              end else begin
                // Move on to the next code; a zero code ends the pass
                if (seq_i.code_avail) begin
                  req_o.load = 1'b1;
                  rem_d      = loaded.rem;
                  weight_d   = loaded.weight;
                  units_d    = loaded.units;
                end
                if (seq_i.code_avail && loaded.units != 4'd0) begin
                  phase_d = PhBlip;
                  timer_d = times_i.value_gap;
                end else begin
                  phase_d = PhWait;
                  timer_d = times_i.tail;
                end
              end
            end
            PhUnitOn: begin
              led_d   = 1'b0;
              timer_d = times_i.flash_off;
              units_d = units_q - 4'd1;
              phase_d = PhDigit;
            end
            PhBlip: begin
              led_d   = 1'b1;
              timer_d = times_i.blip_on;
              phase_d = PhBlipOn;
            end
            PhBlipOn: begin
              led_d   = 1'b0;
              timer_d = times_i.value_gap;
              phase_d = PhDigit;
            end
            default: begin
              phase_d = PhWait;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhWait;
      timer_q  <= '0;
      rem_q    <= '0;
      weight_q <= '0;
      units_q  <= '0;
      ps_q     <= '0;
      led_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      timer_q  <= timer_d;
      rem_q    <= rem_d;
      weight_q <= weight_d;
      units_q  <= units_d;
      ps_q     <= ps_d;
      led_q    <= led_d;
    end
  end

  assign led_d_o = led_d;

endmodule

`default_nettype wire

// ----- hdl/led_error_code_blinker_core.sv -----
// LED error code blinker top level: code queue, register file, result register.
// The block takes one transaction per clock: a base tick, an enqueue of an 8-bit
// error code, or a queue clear. Every transaction is worked off in the cycle it
// is accepted and yields exactly one result (LED level, drop flag, queue fill)
// in an output register in the next cycle; the input side stalls only while that
// result is held by a stalled output. Base ticks are divided by TICK_PRESCALE,
// and all blink durations are counted in the divided ticks. Each pass waits for
// display_ready, shows a header flash, then the queued codes as decimal digits (one
// flash per unit) with a short blip between codes and a tail gap at the end; a later
// zero code ends the pass. Codes sit in a small RAM read one entry ahead of the display
// pointer. Register writes complete in the cycle they are offered (ready is always high).
`default_nettype none
`include "led_error_code_blinker_core_assert.svh"

module led_error_code_blinker_core
  import ledb_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QueueDepthDef,
  parameter int TICK_PRESCALE = TickPrescaleDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [KindW-1:0]   kind_i,
  input  wire logic [CodeW-1:0]   code_i,
  input  wire logic               display_ready_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    led_o,
  output logic                    dropped_o,
  output logic [QueuedW-1:0]      queued_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [TimeW-1:0]   cfg_data_i
);

  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  kind_e             kind;
  logic              in_fire;
  times_t            times_q;
  logic [CntW-1:0]   code_count_q, code_count_d;
  logic [CntW-1:0]   show_index_q, show_index_d;
  logic              full;
  logic              wr_en;
  logic              drop;
  logic              byp_q;
  logic [CodeW-1:0]  byp_data_q;
  logic [CodeW-1:0]  ram_rdata;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  seq_in_t           seq_in;
  seq_req_t          seq_req;
  logic              led_next;
  logic              out_valid_q;
  logic              led_q;
  logic              dropped_q;
  logic [QueuedW-1:0] queued_q;

  assign kind       = kind_e'(kind_i);
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      times_q <= '{hdr_on: HdrOnRst, hdr_off: HdrOffRst, flash_on: FlashOnRst,
                   flash_off: FlashOffRst, digit_gap: DigitGapRst, tail: TailRst,
                   blip_on: BlipOnRst, value_gap: ValueGapRst};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgHdrOn:    times_q.hdr_on    <= cfg_data_i;
        CfgHdrOff:   times_q.hdr_off   <= cfg_data_i;
        CfgFlashOn:  times_q.flash_on  <= cfg_data_i;
        CfgFlashOff: times_q.flash_off <= cfg_data_i;
        CfgDigitGap: times_q.digit_gap <= cfg_data_i;
        CfgTail:     times_q.tail      <= cfg_data_i;
        CfgBlipOn:   times_q.blip_on   <= cfg_data_i;
        CfgValueGap: times_q.value_gap <= cfg_data_i;
      endcase
    end
  end

  // Queue bookkeeping
  assign full = (code_count_q == CntW'(QUEUE_DEPTH));

  always_comb begin
    code_count_d = code_count_q;
    show_index_d = show_index_q;
    wr_en        = 1'b0;
    drop         = 1'b0;
    if (in_fire) begin
      unique case (kind)
        KindTick: begin
          if (seq_req.start) begin
            show_index_d = '0;
          end else if (seq_req.load) begin
            show_index_d = show_index_q + CntW'(1);
          end
        end
        KindPush: begin
          if (full) begin
            drop = 1'b1;
          end else begin
            wr_en        = 1'b1;
            code_count_d = code_count_q + CntW'(1);
          end
        end
        KindClear: begin
          code_count_d = '0;
          show_index_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_addr = code_count_q[AddrW-1:0];
  assign rd_addr = show_index_d[AddrW-1:0];

  ledb_ram #(
    .DATA_W (CodeW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (code_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rdata)
  );

  // Forward a code written to the entry being fetched in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= code_i;
  end

  assign seq_in.base_tick  = (kind == KindTick);
  assign seq_in.clear      = (kind == KindClear);
  assign seq_in.ready      = display_ready_i;
  assign seq_in.code_avail = (show_index_q != code_count_q);
  assign seq_in.head_code  = byp_q ? byp_data_q : ram_rdata;

  ledb_seq #(
    .TICK_PRESCALE (TICK_PRESCALE)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .times_i (times_q),
    .fire_i  (in_fire),
    .seq_i   (seq_in),
    .req_o   (seq_req),
    .led_d_o (led_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_count_q <= '0;
      show_index_q <= '0;
      out_valid_q  <= 1'b0;
      led_q        <= 1'b0;
      dropped_q    <= 1'b0;
      queued_q     <= '0;
    end else begin
      code_count_q <= code_count_d;
      show_index_q <= show_index_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
        led_q       <= led_next;
        dropped_q   <= drop;
        queued_q    <= QueuedW'(code_count_d);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_o       = led_q;
  assign dropped_o   = dropped_q;
  assign queued_o    = queued_q;

  `LEDB_ASSERT(a_show_within_fill, show_index_q <= code_count_q, "show index past fill")
  `LEDB_ASSERT(a_fill_bound, code_count_q <= CntW'(QUEUE_DEPTH), "queue overfilled")
  `LEDB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_q, "result valid out of reset")
  `LEDB_ASSERT(a_result_loaded, in_fire |=> out_valid_q, "accepted item gave no result")
  `LEDB_ASSERT(a_clear_dark, in_fire && kind == KindClear |=> !led_q && queued_q == 4'd0, "clear left LED or queue")

endmodule

`default_nettype wire

// ----- verif/led_error_code_blinker_core_tb.sv -----
// Self-checking testbench for the LED error code blinker core
`default_nettype none

module led_error_code_blinker_core_tb;
  import ledb_pkg::*;

  localparam int Depth         = QueueDepthDef;
  localparam int Prescale      = TickPrescaleDef;
  localparam int WatchdogLimit = 2000;
  localparam int SqueezeCycles = 60;
  localparam logic [KindW-1:0] KindSpare = 2'd3;

  typedef struct packed {
    logic               led;
    logic               dropped;
    logic [QueuedW-1:0] queued;
  } status_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CodeW-1:0] code;
    logic             ready;
    logic             typed;
    status_t          want;
  } stim_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_stall_o;
  logic [KindW-1:0]   kind_i          = KindTick;
  logic [CodeW-1:0]   code_i          = '0;
  logic               display_ready_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i     = 1'b0;
  logic               led_o;
  logic               dropped_o;
  logic [QueuedW-1:0] queued_o;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i     = '0;
  logic [TimeW-1:0]   cfg_data_i      = '0;

  // Side information travelling with the payload of the current item
  logic               row_typed = 1'b0;
  status_t            row_want  = '0;

  // Blinker model state
  logic [TimeW-1:0]   dur [8];
  logic [CodeW-1:0]   codes [Depth];
  int unsigned        n_codes  = 0;
  int unsigned        show_at  = 0;
  int unsigned        prescale = 0;
  phase_e             ph       = PhWait;
  logic [TimeW-1:0]   timer    = '0;
  logic [CodeW-1:0]   rem      = '0;
  logic [DigitW-1:0]  units    = '0;
  logic [WeightW-1:0] weight   = '0;
  logic               lamp     = 1'b0;

  status_t            awaited_status [$];
  stim_t              directed_rows [$];
  logic [TimeW-1:0]   timing_plan [8];
  int                 errors       = 0;
  int                 quiet        = 0;
  int                 sent         = 0;
  bit                 calm         = 1'b0;
  bit                 tx_gappy     = 1'b1;
  bit                 rx_gappy     = 1'b1;
  bit                 squeeze_req  = 1'b0;
  bit                 squeezed     = 1'b0;
  int                 squeeze_left = 0;
  int                 rx_burst     = 0;
  int                 rx_cycles    = 0;

  led_error_code_blinker_core #(
    .QUEUE_DEPTH  (Depth),
    .TICK_PRESCALE(Prescale)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .code_i         (code_i),
    .display_ready_i(display_ready_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_o          (led_o),
    .dropped_o      (dropped_o),
    .queued_o       (queued_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Take the next queued code apart into its leading non-zero digit
  function automatic void fetch_code();
    int unsigned v, w, d;
    if (show_at != n_codes && show_at < Depth) begin
      v = codes[show_at];
      show_at++;
      w = 100;
      d = 0;
      while (w != 0 && d == 0) begin
        d = v / w;
        if (d != 0) v -= d * w;
        else w /= 10;
      end
      rem    = v[CodeW-1:0];
      weight = w[WeightW-1:0];
      units  = d[DigitW-1:0];
    end
  endfunction

  // One prescaled tick of the display sequencer
  function automatic void slow_step(input logic rdy);
    int unsigned w, d;
    if (timer > 1) begin
      timer = timer - 8'd1;
    end else begin
      case (ph)
        PhWait: begin
          if (rdy) begin
            show_at = 0;
            lamp    = 1'b1;
            timer   = dur[CfgHdrOn];
            ph      = PhHeader;
          end
        end
        PhHeader: begin
          lamp  = 1'b0;
          timer = dur[CfgHdrOff];
          fetch_code();
          ph    = PhDigit;
        end
        PhDigit: begin
          if (units != 0) begin
            lamp  = 1'b1;
            timer = dur[CfgFlashOn];
            ph    = PhUnitOn;
          end else if (rem != 0) begin
            // zero digits inside a code only stretch the gap
            w = weight / 10;
            d = 0;
            if (w != 0) d = rem / w;
            rem    = CodeW'(rem - d * w);
            weight = w[WeightW-1:0];
            units  = d[DigitW-1:0];
            timer  = dur[CfgDigitGap];
          end else begin
            fetch_code();
            if (units == 0) begin
              ph    = PhWait;
              timer = dur[CfgTail];
            end else begin
              ph    = PhBlip;
              timer = dur[CfgValueGap];
            end
          end
        end
        PhUnitOn: begin
          lamp  = 1'b0;
          timer = dur[CfgFlashOff];
          units = units - 4'd1;
          ph    = PhDigit;
        end
        PhBlip: begin
          lamp  = 1'b1;
          timer = dur[CfgBlipOn];
          ph    = PhBlipOn;
        end
        PhBlipOn: begin
          lamp  = 1'b0;
          timer = dur[CfgValueGap];
          ph    = PhDigit;
        end
        default: ph = PhWait;
      endcase
    end
  endfunction

  // Apply one transaction and return the status the block should report
  function automatic status_t blink_step(input logic [KindW-1:0] k,
                                         input logic [CodeW-1:0] c,
                                         input logic rdy);
    status_t r;
    r.dropped = 1'b0;
    case (k)
      KindTick: begin
        if (prescale > 1) begin
          prescale--;
        end else begin
          slow_step(rdy);
          prescale = Prescale;
        end
      end
      KindPush: begin
        if (n_codes >= Depth) begin
          r.dropped = 1'b1;
        end else begin
          codes[n_codes] = c;
          n_codes++;
        end
      end
      KindClear: begin
        lamp    = 1'b0;
        n_codes = 0;
        show_at = 0;
        ph      = PhWait;
        foreach (codes[i]) codes[i] = '0;
      end
      default: ;
    endcase
    r.led    = lamp;
    r.queued = n_codes[QueuedW-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic add_row(input logic [KindW-1:0] k, input logic [CodeW-1:0] c,
                         input logic r, input logic typed, input logic led,
                         input logic drop, input int q);
    stim_t s;
    s.kind         = k;
    s.code         = c;
    s.ready        = r;
    s.typed        = typed;
    s.want.led     = led;
    s.want.dropped = drop;
    s.want.queued  = QueuedW'(q);
    directed_rows.push_back(s);
  endtask

  task automatic send(input stim_t s);
    int gap;
    sent++;
    if (sent % 32 == 0) tx_gappy = ($urandom_range(0, 2) != 0);
    if (!calm && tx_gappy && squeeze_left == 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    kind_i          <= s.kind;
    code_i          <= s.code;
    display_ready_i <= s.ready;
    row_typed       <= s.typed;
    row_want        <= s.want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drain, then write every timing register from timing_plan
  task automatic load_timing();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= timing_plan[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk_i) begin
    rx_cycles++;
    if (rx_cycles % 64 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
    if (squeeze_req && !squeezed) begin
      squeezed     = 1'b1;
      squeeze_left = SqueezeCycles;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall_i <= 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst--;
      out_stall_i <= 1'b1;
    end else if (!calm && rx_gappy && $urandom_range(0, 4) == 0) begin
      rx_burst = $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : watch
    status_t want, got;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        dur[cfg_index_i] = cfg_data_i;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (awaited_status.size() == 0) begin
          $display("%0t: result with none expected, actual led %0d dropped %0d queued %0d",
                   $time, led_o, dropped_o, queued_o);
          errors++;
        end else begin
          want = awaited_status.pop_front();
          check_field("led", want.led, led_o);
          check_field("dropped", want.dropped, dropped_o);
          check_field("queued", want.queued, queued_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        got = blink_step(kind_i, code_i, display_ready_i);
        awaited_status.push_back(row_typed ? row_want : got);
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    stim_t       row;
    int unsigned roll;
    int          len;
    dur[CfgHdrOn]    = HdrOnRst;
    dur[CfgHdrOff]   = HdrOffRst;
    dur[CfgFlashOn]  = FlashOnRst;
    dur[CfgFlashOff] = FlashOffRst;
    dur[CfgDigitGap] = DigitGapRst;
    dur[CfgTail]     = TailRst;
    dur[CfgBlipOn]   = BlipOnRst;
    dur[CfgValueGap] = ValueGapRst;
    foreach (codes[i]) codes[i] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // First tick after reset acts at once, but the display is not ready
    add_row(KindTick, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0, 0);
    // Fill the queue: extremes, code zero second, trailing and inner zeros
    add_row(KindPush, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0, 1);
    add_row(KindPush, 8'd0,   1'b1, 1'b1, 1'b0, 1'b0, 2);
    add_row(KindPush, 8'd100, 1'b0, 1'b1, 1'b0, 1'b0, 3);
    add_row(KindPush, 8'd1,   1'b1, 1'b1, 1'b0, 1'b0, 4);
    add_row(KindPush, 8'd205, 1'b0, 1'b1, 1'b0, 1'b0, 5);
    add_row(KindPush, 8'd10,  1'b1, 1'b1, 1'b0, 1'b0, 6);
    add_row(KindPush, 8'd99,  1'b0, 1'b1, 1'b0, 1'b0, 7);
    add_row(KindPush, 8'd128, 1'b1, 1'b1, 1'b0, 1'b0, 8);
    add_row(KindPush, 8'd7,   1'b0, 1'b1, 1'b0, 1'b0, 9);
    add_row(KindPush, 8'd250, 1'b1, 1'b1, 1'b0, 1'b0, 10);
    // Queue full: drop
    add_row(KindPush, 8'd3,   1'b0, 1'b1, 1'b0, 1'b1, 10);
    add_row(KindSpare, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 10);
    // Ready is ignored until the prescaler runs out
    repeat (9) add_row(KindTick, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0, 0);
    add_row(KindTick, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 0);
    add_row(KindClear, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0, 0);
    add_row(KindPush, 8'd0,  1'b0, 1'b1, 1'b0, 1'b0, 1);
    foreach (directed_rows[i]) send(directed_rows[i]);

    for (int stage = 0; stage < 6; stage++) begin
      for (int i = 0; i < 8; i++) begin
        case (stage)
          0:       timing_plan[i] = 8'd1;
          1:       timing_plan[i] = TimeW'($urandom_range(1, 3));
          2:       timing_plan[i] = TimeW'($urandom_range(0, 2));
          3:       timing_plan[i] = TimeW'($urandom_range(1, 4));
          4:       timing_plan[i] = TimeW'($urandom_range(1, 6));
          default: timing_plan[i] = 8'd255;
        endcase
      end
      load_timing();
      len = (stage == 5) ? 100 : 130;
      for (int n = 0; n < len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 90)      row.kind = KindTick;
        else if (roll < 97) row.kind = KindPush;
        else if (roll < 99) row.kind = KindClear;
        else                row.kind = KindSpare;
        case ($urandom_range(0, 4))
          0:       row.code = 8'd0;
          1:       row.code = 8'hFF;
          2:       row.code = CodeW'($urandom_range(1, 25) * 10);
          default: row.code = CodeW'($urandom_range(0, 255));
        endcase
        row.ready = ($urandom_range(0, 4) != 0);
        row.typed = 1'b0;
        row.want  = '0;
        // Hold the receiver off mid-run so the input side backs up
        if (stage == 2 && n == 50) squeeze_req = 1'b1;
        if (stage == 5 && n == len - 60) calm = 1'b1;
        send(row);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0 && awaited_status.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
